// ===== hw/rtl/sal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sal_pkg;

  localparam int unsigned QueueDepth = 2;

  // Header byte layout
  localparam logic [7:0] TypeMask    = 8'h60;
  localparam logic [7:0] CountMask   = 8'h1f;
  localparam logic [7:0] AllowedMask = 8'h80;
  localparam int unsigned TypeShift  = 5;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PLMN   = 2'd1,
    KIND_TAC    = 2'd2,
    KIND_TRUNC  = 2'd3
  } rec_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } sal_in_t;

  typedef struct packed {
    rec_kind_e   record_kind;
    logic [23:0] record_value;
    logic [7:0]  partial_list_number;
    logic        allowed_flag;
    logic [1:0]  list_kind;
    logic [5:0]  element_total;
    logic        element_end;
  } sal_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sal_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sal_front import sal_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sal_in_t  in_item_i,
  input  wire logic     q_full_i,
  output logic          q_push_o,
  output sal_out_t      q_item_o
);

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_PLMN = 2'd1,
    PH_TAC  = 2'd2
  } phase_e;

  localparam logic [1:0] ListTacOnly  = 2'd1;
  localparam logic [1:0] ListPairs    = 2'd2;
  localparam logic [1:0] ListPlmnOnly = 2'd3;

  phase_e      phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic [23:0] acc_q, acc_d;
  logic [5:0]  left_q, left_d;
  logic [1:0]  kind_q, kind_d;
  logic        allowed_q, allowed_d;
  logic [5:0]  total_q, total_d;
  logic [7:0]  ordinal_q, ordinal_d;

  logic        accept;
  logic [1:0]  pos_inc;
  logic [23:0] acc_shift;
  logic [5:0]  left_dec;
  logic [7:0]  data;
  logic        fin;
  logic        emit;
  sal_out_t    rec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign data       = in_item_i.data_byte;
  assign fin        = in_item_i.final_byte;
  assign pos_inc    = pos_q + 2'd1;
  assign acc_shift  = {acc_q[15:0], data};
  assign left_dec   = (left_q > 6'd1) ? left_q - 6'd1 : 6'd0;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    left_d    = left_q;
    kind_d    = kind_q;
    allowed_d = allowed_q;
    total_d   = total_q;
    ordinal_d = ordinal_q;
    emit      = 1'b0;
    rec       = '0;
    rec.record_kind = KIND_HEADER;

    if (accept) begin
      unique case (phase_q)
        PH_PLMN, PH_TAC: begin
          acc_d            = acc_shift;
          rec.record_value = acc_shift;
          pos_d            = pos_inc;
          if (pos_inc == 2'd3) begin
            emit  = 1'b1;
            pos_d = 2'd0;
            acc_d = '0;
            if (phase_q == PH_PLMN) begin
              rec.record_kind = KIND_PLMN;
              phase_d = (kind_q == ListPlmnOnly) ? PH_HDR : PH_TAC;
            end else begin
              rec.record_kind = KIND_TAC;
              left_d = left_dec;
              if (left_dec == 6'd0) begin
                phase_d = PH_HDR;
              end else begin
                phase_d = (kind_q == ListPairs) ? PH_PLMN : PH_TAC;
              end
            end
          end
        end
        default: begin
          // header byte; the unused phase code lands here too
          if (ordinal_q != 8'hff) ordinal_d = ordinal_q + 8'd1;
          allowed_d = |(data & AllowedMask);
          kind_d    = 2'((data & TypeMask) >> TypeShift);
          total_d   = {1'b0, 5'(data & CountMask)} + 6'd1;
          left_d    = (kind_d == ListTacOnly) ? 6'd1 : total_d;
          pos_d     = 2'd0;
          acc_d     = '0;
          emit      = 1'b1;
          rec.record_kind  = KIND_HEADER;
          rec.record_value = {16'h0000, data};
          phase_d   = PH_PLMN;
        end
      endcase

      if (fin && phase_d != PH_HDR) begin
        rec.record_kind = KIND_TRUNC;
        emit = 1'b1;
      end

      rec.partial_list_number = ordinal_d;
      rec.allowed_flag        = allowed_d;
      rec.list_kind           = kind_d;
      rec.element_total       = total_d;
      rec.element_end         = fin;

      // element closes: start afresh on the next byte
      if (fin) begin
        phase_d   = PH_HDR;
        ordinal_d = '0;
        pos_d     = 2'd0;
        acc_d     = '0;
      end
    end
  end

  assign q_push_o = accept && emit;
  assign q_item_o = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      pos_q     <= 2'd0;
      acc_q     <= '0;
      left_q    <= '0;
      kind_q    <= 2'd0;
      allowed_q <= 1'b0;
      total_q   <= 6'd1;
      ordinal_q <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      acc_q     <= acc_d;
      left_q    <= left_d;
      kind_q    <= kind_d;
      allowed_q <= allowed_d;
      total_q   <= total_d;
      ordinal_q <= ordinal_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sal_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sal_queue import sal_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire sal_out_t push_item_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output sal_out_t      pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  sal_out_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sal_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sal_back import sal_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_valid_i,
  input  wire sal_out_t q_item_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sal_out_t      out_item_o
);

  logic     valid_q;
  sal_out_t item_q;
  logic     load;

  // refill whenever the output slot is empty or being taken
  assign load        = q_valid_i && (!valid_q || out_ready_i);
  assign q_pop_o     = load;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i) begin
    if (load) item_q <= q_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/service_area_list_parser_core.sv =====
// Service area list element parser. Takes the element contents one byte per
// item with a flag on its last byte, and emits one record for each partial
// list header, each completed PLMN and each completed TAC (raw bytes, first
// byte in the top of record_value), or a single truncation record when the
// element ends inside a field or with a PLMN or TAC still due. A byte is
// accepted every cycle while the queue is not full; the parser state
// updates on each accepted byte, so sustained rate is one item per clock
// while the output keeps up. A record from a taken byte passes a short
// queue (QueueDepth entries) and then the output register. Input ready
// drops only while the queue is full. Mid-field bytes give no record.
`timescale 1ns / 1ps
`default_nettype none

module service_area_list_parser_core import sal_pkg::*; #(
  parameter int unsigned QueueDepth = sal_pkg::QueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sal_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sal_out_t      out_item_o
);

  logic     q_full, q_push, q_pop, q_valid;
  sal_out_t q_wr_item, q_rd_item;

  sal_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_wr_item)
  );

  sal_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_wr_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_rd_item)
  );

  sal_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_rd_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_trunc_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.record_kind == KIND_TRUNC |-> out_item_o.element_end)
    else $error("truncation record without element end");

  a_header_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.record_kind == KIND_HEADER |->
      out_item_o.record_value[23:8] == 16'h0000 &&
      out_item_o.list_kind == out_item_o.record_value[6:5] &&
      out_item_o.allowed_flag == out_item_o.record_value[7] &&
      out_item_o.element_total == {1'b0, out_item_o.record_value[4:0]} + 6'd1)
    else $error("header record fields disagree with header byte");

  a_ordinal_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.partial_list_number != 8'h00)
    else $error("record emitted outside a partial list");

  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while output register empty");

endmodule

`default_nettype wire
